// ===== design/assert_macros.svh =====
// Assertion macros included by the free-list heap allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication from a trigger to a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) else $error(msg);

`endif

// ===== design/flal_pkg.sv =====
// Package with the types, codes and helpers of the free-list heap allocator.
`timescale 1ns / 1ps
package flal_pkg;

  localparam int HEAP_UNITS = 4096;
  localparam int UNIT_BYTES = 16;
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int IDX_W = $clog2(HEAP_UNITS);
  localparam int SIZE_W = IDX_W + 1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_ZERO = 2'd2,
    ST_BAD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_SPARE = 2'd3
  } policy_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] byte_count;
    logic [11:0] block_address;
  } req_t;

  typedef struct packed {
    logic [11:0] address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  next;
  } hdr_t;

  function automatic logic [SIZE_W-1:0] cap_size(input logic [SIZE_W:0] s);
    logic [SIZE_W-1:0] r;
    if (s > (SIZE_W + 1)'(HEAP_UNITS)) begin
      r = SIZE_W'(HEAP_UNITS);
    end else begin
      r = s[SIZE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/flal_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module flal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/free_list_heap_allocator.sv =====
// Allocate: reads the rover header, walks the list, carves the block if it is split;
// a zero size goes straight to the result. Release: reads the block header, walks the
// list, writes the block and the previous header; address 0 ends with no read, an empty
// header with no walk. One request at a time; a walk reads one header a cycle and stops
// after 4097 headers. After reset a clearing pass initialises the header RAM; no word is
// accepted until it ends. The result register lets a new word enter while one waits.
`timescale 1ns / 1ps
module free_list_heap_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  flal_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output flal_pkg::rsp_t out_data_o
);
  import flal_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [9:0] {
    S_INIT    = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_A_HEAD  = 10'b0000000100,
    S_A_WALK  = 10'b0000001000,
    S_A_CARVE = 10'b0000010000,
    S_R_BP    = 10'b0000100000,
    S_R_WALK  = 10'b0001000000,
    S_R_NX    = 10'b0010000000,
    S_R_WP    = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] pol_q;
  logic [IDX_W-1:0] rover_q, rover_d, p_q, p_d, prev_q, prev_d;
  logic [SIZE_W-1:0] prev_size_q, prev_size_d, n_q, n_d, steps_q, steps_d;
  logic found_q, found_d;
  logic [IDX_W-1:0] best_q, best_d, best_prev_q, best_prev_d, best_next_q, best_next_d;
  logic [SIZE_W-1:0] best_size_q, best_size_d;
  logic [IDX_W-1:0] bp_q, bp_d, pnx_q, pnx_d, nb_next_q, nb_next_d;
  logic [SIZE_W-1:0] bsz_q, bsz_d, psz_q, psz_d, nb_size_q, nb_size_d;
  logic [11:0] res_addr_q, res_addr_d;
  status_e res_status_q, res_status_d;
  logic out_valid_q, out_valid_d;
  rsp_t out_data_q, out_data_d;

  logic ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  hdr_t ram_wdata, ram_rdata;

  flal_ram #(
    .WIDTH($bits(hdr_t)),
    .DEPTH(HEAP_UNITS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    logic [16:0] bytes_up;
    logic fit, exact, ranked, better, take;
    logic [IDX_W-1:0] cb, cprev, cnext, qaddr;
    logic [SIZE_W-1:0] csize, rest;
    logic cfound, placed, merge_hi;
    state_d       = state_q;
    rover_d       = rover_q;
    p_d           = p_q;
    prev_d        = prev_q;
    prev_size_d   = prev_size_q;
    n_d           = n_q;
    steps_d       = steps_q;
    found_d       = found_q;
    best_d        = best_q;
    best_prev_d   = best_prev_q;
    best_next_d   = best_next_q;
    best_size_d   = best_size_q;
    bp_d          = bp_q;
    pnx_d         = pnx_q;
    nb_next_d     = nb_next_q;
    bsz_d         = bsz_q;
    psz_d         = psz_q;
    nb_size_d     = nb_size_q;
    res_addr_d    = res_addr_q;
    res_status_d  = res_status_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = p_q;
    ram_raddr     = p_q;
    ram_wdata     = '0;
    bytes_up      = {1'b0, in_data_i.byte_count} + 17'(UNIT_BYTES - 1);
    fit           = ram_rdata.size >= n_q;
    exact         = ram_rdata.size == n_q;
    ranked        = (pol_q == POL_BEST) || (pol_q == POL_WORST);
    better        = (pol_q == POL_BEST) ? (ram_rdata.size < best_size_q)
                                        : (ram_rdata.size > best_size_q);
    take          = fit && ranked && (!found_q || better);
    cfound        = found_q || take;
    cb            = take ? p_q : best_q;
    cprev         = take ? prev_q : best_prev_q;
    cnext         = take ? ram_rdata.next : best_next_q;
    csize         = take ? ram_rdata.size : best_size_q;
    if (fit && !ranked) begin
      cb    = p_q;
      cprev = prev_q;
      cnext = ram_rdata.next;
      csize = ram_rdata.size;
    end
    rest          = csize - n_q;
    qaddr         = cb + rest[IDX_W-1:0];
    placed        = ((bp_q > p_q) && (bp_q < ram_rdata.next)) ||
                    ((p_q >= ram_rdata.next) && ((bp_q > p_q) || (bp_q < ram_rdata.next)));
    merge_hi      = ({1'b0, bp_q} + {1'b0, bsz_q}) == (SIZE_W + 1)'(pnx_q);

    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        if (p_q == IDX_W'(0)) begin
          ram_wdata = '{size: '0, next: IDX_W'(1)};
        end else if (p_q == IDX_W'(1)) begin
          ram_wdata = '{size: SIZE_W'(HEAP_UNITS - 1), next: '0};
        end
        p_d = p_q + IDX_W'(1);
        if (p_q == IDX_W'(HEAP_UNITS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        res_addr_d   = '0;
        res_status_d = ST_OK;
        if (in_valid_i) begin
          if (!in_data_i.mode) begin
            if (in_data_i.byte_count == 16'd0) begin
              res_status_d = ST_ZERO;
              state_d      = S_DONE;
            end else begin
              n_d       = SIZE_W'(bytes_up >> UNIT_SHIFT) + SIZE_W'(1);
              ram_re    = 1'b1;
              ram_raddr = rover_q;
              prev_d    = rover_q;
              found_d   = 1'b0;
              steps_d   = '0;
              state_d   = S_A_HEAD;
            end
          end else begin
            if (in_data_i.block_address == 12'd0) begin
              res_status_d = ST_BAD;
              state_d      = S_DONE;
            end else begin
              bp_d      = in_data_i.block_address - 12'd1;
              ram_re    = 1'b1;
              ram_raddr = in_data_i.block_address - 12'd1;
              state_d   = S_R_BP;
            end
          end
        end
      end
      S_A_HEAD: begin
        prev_size_d = ram_rdata.size;
        p_d         = ram_rdata.next;
        ram_re      = 1'b1;
        ram_raddr   = ram_rdata.next;
        state_d     = S_A_WALK;
      end
      S_A_WALK: begin
        found_d     = cfound;
        best_d      = cb;
        best_prev_d = cprev;
        best_next_d = cnext;
        best_size_d = csize;
        if (fit && exact) begin
          ram_we     = 1'b1;
          ram_waddr  = prev_q;
          ram_wdata  = '{size: prev_size_q, next: ram_rdata.next};
          rover_d    = prev_q;
          res_addr_d = p_q + 12'd1;
          state_d    = S_DONE;
        end else if ((fit && !ranked) || ((p_q == rover_q) && cfound)) begin
          ram_we    = 1'b1;
          ram_waddr = cb;
          ram_wdata = '{size: rest, next: cnext};
          ram_re    = 1'b1;
          ram_raddr = qaddr;
          p_d       = qaddr;
          rover_d   = cprev;
          state_d   = S_A_CARVE;
        end else if ((p_q == rover_q) || (steps_q == SIZE_W'(HEAP_UNITS))) begin
          res_status_d = ST_OOM;
          state_d      = S_DONE;
        end else begin
          prev_d      = p_q;
          prev_size_d = ram_rdata.size;
          p_d         = ram_rdata.next;
          ram_re      = 1'b1;
          ram_raddr   = ram_rdata.next;
          steps_d     = steps_q + SIZE_W'(1);
        end
      end
      S_A_CARVE: begin
        ram_we     = 1'b1;
        ram_waddr  = p_q;
        ram_wdata  = '{size: n_q, next: ram_rdata.next};
        res_addr_d = p_q + 12'd1;
        state_d    = S_DONE;
      end
      S_R_BP: begin
        if (ram_rdata.size == '0) begin
          res_status_d = ST_BAD;
          state_d      = S_DONE;
        end else begin
          bsz_d     = ram_rdata.size;
          p_d       = rover_q;
          steps_d   = '0;
          ram_re    = 1'b1;
          ram_raddr = rover_q;
          state_d   = S_R_WALK;
        end
      end
      S_R_WALK: begin
        if (placed) begin
          psz_d     = ram_rdata.size;
          pnx_d     = ram_rdata.next;
          ram_re    = 1'b1;
          ram_raddr = ram_rdata.next;
          state_d   = S_R_NX;
        end else if (steps_q == SIZE_W'(HEAP_UNITS)) begin
          res_status_d = ST_BAD;
          state_d      = S_DONE;
        end else begin
          p_d       = ram_rdata.next;
          ram_re    = 1'b1;
          ram_raddr = ram_rdata.next;
          steps_d   = steps_q + SIZE_W'(1);
        end
      end
      S_R_NX: begin
        if (merge_hi) begin
          nb_size_d = cap_size({1'b0, bsz_q} + {1'b0, ram_rdata.size});
          nb_next_d = ram_rdata.next;
        end else begin
          nb_size_d = bsz_q;
          nb_next_d = pnx_q;
        end
        ram_we    = 1'b1;
        ram_waddr = bp_q;
        ram_wdata = merge_hi
                    ? '{size: cap_size({1'b0, bsz_q} + {1'b0, ram_rdata.size}),
                        next: ram_rdata.next}
                    : '{size: bsz_q, next: pnx_q};
        state_d   = S_R_WP;
      end
      S_R_WP: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        if (({1'b0, p_q} + {1'b0, psz_q}) == (SIZE_W + 1)'(bp_q)) begin
          ram_wdata = '{size: cap_size({1'b0, psz_q} + {1'b0, nb_size_q}), next: nb_next_q};
        end else begin
          ram_wdata = '{size: psz_q, next: bp_q};
        end
        rover_d = p_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
      out_valid_d = 1'b1;
      out_data_d  = '{address: res_addr_q, status: res_status_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      pol_q       <= POL_FIRST;
      rover_q     <= '0;
      p_q         <= '0;
      steps_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rover_q     <= rover_d;
      p_q         <= p_d;
      steps_q     <= steps_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        pol_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q       <= prev_d;
    prev_size_q  <= prev_size_d;
    n_q          <= n_d;
    best_q       <= best_d;
    best_prev_q  <= best_prev_d;
    best_next_q  <= best_next_d;
    best_size_q  <= best_size_d;
    bp_q         <= bp_d;
    pnx_q        <= pnx_d;
    nb_next_q    <= nb_next_d;
    bsz_q        <= bsz_d;
    psz_q        <= psz_d;
    nb_size_q    <= nb_size_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
  end

  `ASSERT_IMPLIES(a_no_accept_in_init, state_q == S_INIT, !in_ready_o, "word accepted during clearing pass")
  `ASSERT_ALWAYS(a_walk_bounded, steps_q <= SIZE_W'(HEAP_UNITS), "list walk ran past its bound")
  `ASSERT_IMPLIES(a_err_addr_zero, out_valid_o && (out_data_o.status != ST_OK), out_data_o.address == 12'd0, "error result carries an address")

endmodule
